@@ rtl/core/rgbc_pkg.sv @@
// shared constants and types of the rgb 3x3 convolution core
`timescale 1ns / 1ps
package rgbc_pkg;

  // geometry limits
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;
  localparam int PIX_MAX       = 255;

  // coefficient format
  localparam int NUM_TAPS  = 9;
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 17;

  // register field widths
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_TAPS03 = 3'd2,
    REG_TAPS47 = 3'd3,
    REG_TAP8   = 3'd4
  } reg_idx_t;

  // reset values
  localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [63:0]             RST_TAPS03 = 64'd0;
  localparam logic [63:0]             RST_TAPS47 = 64'd4096;
  localparam logic [15:0]             RST_TAP8   = 16'd0;

  // one rgb pixel: red 7:0, green 15:8, blue 23:16
  typedef logic [23:0] pix_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [15:0] tap_t;

endpackage

@@ rtl/core/rgbc_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rgb_conv3x3_zero_pad_core.sv @@
// top level of the streaming rgb 3x3 convolution core with zero padding
`timescale 1ns / 1ps
// Streaming 3x3 convolution of an RGB frame given in raster order, one pixel per
// clock while not stalled. Two row memories (MAX_WIDTH x 24 bit, registered read)
// hold the two previous rows; each accepted pixel reads its column, and in the read
// stage after it the shifted rows are written back and a 3x3 window register moves.
// A 9-stage pipeline then applies the signed Q4.12 taps in row-major order, one tap
// per stage with truncation toward zero, and a final register clamps to 0..255. The
// output pixel belongs to the centre taken one row plus one pixel earlier. After the
// last pixel of a frame, send width+1 drain items to flush the remaining outputs;
// the last one carries frame_end. An out_stall while an output is valid freezes the
// whole pipeline and is reflected combinationally on in_stall. Writing width or
// height restarts the stream.
module rgb_conv3x3_zero_pad_core #(
  parameter int MAX_WIDTH = rgbc_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_pixel_red,
  input  logic [7:0]                     in_pixel_green,
  input  logic [7:0]                     in_pixel_blue,
  input  logic                           in_drain,
  // filtered output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_frame_end,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = HEIGHT_REG_W;
  localparam int NST = NUM_TAPS + 1;

  // configuration registers
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [63:0]             taps03_r;
  logic [63:0]             taps47_r;
  logic [15:0]             tap8_r;
  logic                    cfg_wr;
  logic                    restart;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign restart   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      taps03_r <= RST_TAPS03;
      taps47_r <= RST_TAPS47;
      tap8_r   <= RST_TAP8;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_REG_W-1:0];
        REG_TAPS03: taps03_r <= cfg_data;
        REG_TAPS47: taps47_r <= cfg_data;
        REG_TAP8:   tap8_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry, saturated
  logic [WW-1:0] w_eff;
  logic [WW-1:0] w_m1;
  logic [HW-1:0] h_eff;
  logic [HW-1:0] h_m1;

  always_comb begin
    if (width_r < WIDTH_REG_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r < HW'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (height_r > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    w_m1 = w_eff - WW'(1);
    h_m1 = h_eff - HW'(1);
  end

  // tap table
  tap_t taps [NUM_TAPS];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      taps[k]     = taps03_r[16*k +: 16];
      taps[k + 4] = taps47_r[16*k +: 16];
    end
    taps[8] = tap8_r;
  end

  // pipeline advance
  logic out_valid_r;
  logic adv;
  logic accept;
  logic drop;
  logic proc;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // position counters
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] ox_r, ox_nxt;
  logic [HW-1:0] oy_r, oy_nxt;
  logic          in_frame;
  logic          emit;
  logic          fe;

  always_comb begin
    in_frame   = in_row_r < h_eff;
    drop       = in_frame && in_drain;
    proc       = accept && !drop;
    emit       = (in_row_r >= HW'(2)) || (in_row_r == HW'(1) && in_col_r != '0);
    fe         = emit && WW'(ox_r) == w_m1 && oy_r == h_m1;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    if (proc) begin
      if (WW'(in_col_r) == w_m1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + HW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (fe) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        ox_nxt     = '0;
        oy_nxt     = '0;
      end else if (emit) begin
        if (WW'(ox_r) == w_m1) begin
          ox_nxt = '0;
          oy_nxt = oy_r + HW'(1);
        end else begin
          ox_nxt = ox_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r <= '0;
      in_row_r <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
    end
  end

  // row memories
  logic          s1_v_r;
  logic [CW-1:0] s1_col_r;
  pix_t          s1_new_r;
  logic          s1_emit_r;
  logic          s1_fe_r;
  logic [3:0]    s1_mask_r;  // top, bottom, left, right
  logic          s1_fwd_r;
  pix_t          s1_fwd_top_r;
  pix_t          s1_fwd_mid_r;
  pix_t          up_rdata;
  pix_t          lo_rdata;
  pix_t          top;
  pix_t          mid;
  pix_t          newpix;
  logic          wr_en;

  assign wr_en  = adv && s1_v_r;
  assign newpix = in_frame ? {in_pixel_blue, in_pixel_green, in_pixel_red} : '0;
  assign top    = s1_fwd_r ? s1_fwd_top_r : up_rdata;
  assign mid    = s1_fwd_r ? s1_fwd_mid_r : lo_rdata;

  rgbc_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (proc),
    .raddr (in_col_r),
    .rdata (up_rdata)
  );

  rgbc_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_ram_lower (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (s1_new_r),
    .re    (proc),
    .raddr (in_col_r),
    .rdata (lo_rdata)
  );

  // read stage: item info waits for the memory data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r     <= in_col_r;
      s1_new_r     <= newpix;
      s1_emit_r    <= emit;
      s1_fe_r      <= fe;
      s1_mask_r    <= {oy_r == '0, oy_r == h_m1, ox_r == '0, WW'(ox_r) == w_m1};
      s1_fwd_r     <= wr_en && s1_col_r == in_col_r;
      s1_fwd_top_r <= mid;
      s1_fwd_mid_r <= s1_new_r;
    end
  end

  // 3x3 window
  pix_t win_r   [NUM_TAPS];
  pix_t win_nxt [NUM_TAPS];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3 + 1];
      win_nxt[r*3 + 1] = win_r[r*3 + 2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_new_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else if (wr_en) begin
      win_r <= win_nxt;
    end
  end

  // masked window for the tap pipeline
  pix_t win_msk [NUM_TAPS];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1_mask_r[3]) || (r == 2 && s1_mask_r[2]) ||
            (c == 0 && s1_mask_r[1]) || (c == 2 && s1_mask_r[0])) begin
          win_msk[r*3 + c] = '0;
        end else begin
          win_msk[r*3 + c] = win_nxt[r*3 + c];
        end
      end
    end
  end

  // one tap: acc = trunc((acc * 4096 + p * tap) / 4096)
  function automatic acc_t tap_step(acc_t acc, logic [7:0] p, tap_t tap);
    logic signed [24:0] prod;
    logic signed [29:0] sum;
    logic signed [29:0] q;
    begin
      prod = $signed({1'b0, p}) * tap;
      sum  = (30'(acc) <<< FRAC_BITS) + 30'(prod);
      if (sum < 0) begin
        q = (sum + 30'sd4095) >>> FRAC_BITS;
      end else begin
        q = sum >>> FRAC_BITS;
      end
      tap_step = q[ACC_W-1:0];
    end
  endfunction

  // tap pipeline: stage j holds the sums after j taps
  logic sv_r  [NST];
  logic sfe_r [NST];
  pix_t spix_r [NST][NUM_TAPS];
  acc_t sacc_r [NST][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) begin
        sv_r[j] <= 1'b0;
      end
    end else if (adv) begin
      sv_r[0] <= s1_v_r && s1_emit_r;
      for (int j = 1; j < NST; j++) begin
        sv_r[j] <= sv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sfe_r[0]  <= s1_fe_r;
      spix_r[0] <= win_msk;
      for (int ch = 0; ch < 3; ch++) begin
        sacc_r[0][ch] <= '0;
      end
      for (int j = 1; j < NST; j++) begin
        sfe_r[j]  <= sfe_r[j-1];
        spix_r[j] <= spix_r[j-1];
        for (int ch = 0; ch < 3; ch++) begin
          sacc_r[j][ch] <= tap_step(sacc_r[j-1][ch], spix_r[j-1][j-1][8*ch +: 8],
                                    taps[j-1]);
        end
      end
    end
  end

  // clamp and output register
  logic [7:0] clamped [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (sacc_r[NST-1][ch] < 0) begin
        clamped[ch] = 8'd0;
      end else if (sacc_r[NST-1][ch] > ACC_W'(PIX_MAX)) begin
        clamped[ch] = 8'(PIX_MAX);
      end else begin
        clamped[ch] = sacc_r[NST-1][ch][7:0];
      end
    end
  end

  logic [7:0] out_red_r;
  logic [7:0] out_green_r;
  logic [7:0] out_blue_r;
  logic       out_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r   <= clamped[0];
      out_green_r <= clamped[1];
      out_blue_r  <= clamped[2];
      out_fe_r    <= sfe_r[NST-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_frame_end = out_fe_r;

endmodule

@@ test/rgb_conv3x3_zero_pad_core_test.sv @@
// testbench for the streaming rgb 3x3 convolution core: directed frame, random frames, extremes
`timescale 1ns / 1ps
module rgb_conv3x3_zero_pad_core_test;
  import rgbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } filt_pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       drn;
    logic       typed;
    logic [7:0] exp_red;
    logic [7:0] exp_green;
    logic [7:0] exp_blue;
    logic       exp_fend;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_pixel_red;
  logic [7:0] in_pixel_green;
  logic [7:0] in_pixel_blue;
  logic in_drain;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic out_frame_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rgb_conv3x3_zero_pad_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_red(in_pixel_red), .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue), .in_drain(in_drain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and pipeline state
  logic [WIDTH_REG_W-1:0]  ref_width;
  logic [HEIGHT_REG_W-1:0] ref_height;
  logic [63:0] ref_taps03;
  logic [63:0] ref_taps47;
  logic [15:0] ref_tap8;
  pix_t row_upper [DEF_MAX_WIDTH];
  pix_t row_lower [DEF_MAX_WIDTH];
  pix_t win [NUM_TAPS];
  int unsigned col_pos, row_pos, out_pos;

  filt_pix_t pending_pix [$];
  int mismatches = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 0;
  bit long_hold_req = 0;

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int unsigned eff_w();
    int unsigned w;
    w = ref_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = ref_height;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic tap_t tap_of(int k);
    if (k < 4) return tap_t'(ref_taps03[16*k +: 16]);
    if (k < 8) return tap_t'(ref_taps47[16*(k-4) +: 16]);
    return tap_t'(ref_tap8);
  endfunction

  function automatic void restart_stream();
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // convolution predictor for one accepted transaction
  function automatic bit filter_step(input logic [7:0] r, g, b, input logic d,
                                     output filt_pix_t res);
    int unsigned w, h, n, ox, oy, c;
    pix_t newpix, top, mid;
    int acc;
    longint v;
    int p;
    w = eff_w();
    h = eff_h();
    res = '0;
    if (row_pos < h && d) return 0;
    newpix = (row_pos < h) ? {b, g, r} : '0;
    c = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
    top = row_upper[c];
    mid = row_lower[c];
    row_upper[c] = mid;
    row_lower[c] = newpix;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = newpix;
    n = row_pos * w + col_pos;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (n < w + 1) return 0;
    ox = out_pos % w;
    oy = out_pos / w;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int ri = 0; ri < 3; ri++) begin
        if ((ri == 0 && oy == 0) || (ri == 2 && oy + 1 >= h)) continue;
        for (int ci = 0; ci < 3; ci++) begin
          if ((ci == 0 && ox == 0) || (ci == 2 && ox + 1 >= w)) continue;
          p = win[ri*3+ci][8*ch +: 8];
          v = longint'(acc) * 4096 + longint'(p) * longint'(tap_of(ri*3+ci));
          acc = int'(v / 4096);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > PIX_MAX) acc = PIX_MAX;
      case (ch)
        0: res.red = acc[7:0];
        1: res.green = acc[7:0];
        default: res.blue = acc[7:0];
      endcase
    end
    if (out_pos + 1 >= w * h) begin
      res.fend = 1;
      restart_stream();
    end else begin
      res.fend = 0;
      out_pos++;
    end
    return 1;
  endfunction

  // drive one pixel transaction, predict on acceptance, optional gap after
  task automatic send_pix(input logic [7:0] r, g, b, input logic d, input bit typed,
                          input filt_pix_t typed_res);
    filt_pix_t res;
    int gap;
    in_valid <= 1;
    in_pixel_red <= r;
    in_pixel_green <= g;
    in_pixel_blue <= b;
    in_drain <= d;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (filter_step(r, g, b, d, res)) pending_pix.push_back(typed ? typed_res : res);
    if (!calm && $urandom_range(3) == 0) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write transaction, block assumed idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_WIDTH: begin
        ref_width = data[WIDTH_REG_W-1:0];
        restart_stream();
      end
      REG_HEIGHT: begin
        ref_height = data[HEIGHT_REG_W-1:0];
        restart_stream();
      end
      REG_TAPS03: ref_taps03 = data;
      REG_TAPS47: ref_taps47 = data;
      REG_TAP8: ref_tap8 = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] rand_chan();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_tap(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(8191)) - 16'd4096;
      default: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // one frame of random pixels, optionally cut short, then the flush items if not cut
  task automatic run_frame(input int unsigned w, h, input bit cut);
    int unsigned total;
    filt_pix_t none;
    none = '0;
    total = cut ? $urandom_range(w * h - 1, 1) : w * h;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(24) == 0) send_pix(rand_chan(), rand_chan(), rand_chan(), 1, 0, none);
      send_pix(rand_chan(), rand_chan(), rand_chan(), 0, 0, none);
    end
    if (!cut)
      for (int unsigned i = 0; i <= w; i++)
        send_pix(rand_chan(), rand_chan(), rand_chan(), logic'($urandom_range(1)), 0, none);
  endtask

  // result side: check and stall pattern
  initial begin
    int stall_left, free_left;
    filt_pix_t want;
    out_stall = 1;
    stall_left = 0;
    free_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_pix.size() == 0) begin
          note_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d fe=%0b",
                                  out_red, out_green, out_blue, out_frame_end));
        end else begin
          want = pending_pix.pop_front();
          if (out_red !== want.red || out_green !== want.green ||
              out_blue !== want.blue || out_frame_end !== want.fend)
            note_mismatch($sformatf("exp r=%0d g=%0d b=%0d fe=%0b got r=%0d g=%0d b=%0d fe=%0b",
                                    want.red, want.green, want.blue, want.fend,
                                    out_red, out_green, out_blue, out_frame_end));
        end
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        stall_left = 400;
        free_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else if (free_left > 0 || calm) begin
        if (free_left > 0) free_left--;
        out_stall <= 0;
      end else if ($urandom_range(2) == 0) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 0);
        out_stall <= 1;
      end else begin
        free_left = ($urandom_range(5) == 0) ? $urandom_range(60, 20) : $urandom_range(4, 0);
        out_stall <= 0;
      end
    end
  end

  // identity taps from reset, 3x3 frame: each output equals its centre pixel
  dir_row_t dir_tab [14] = '{
    '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd10,  8'd20,  8'd30,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd128, 8'd64,  8'd32,  1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
    '{8'd255, 8'd0,   8'd255, 1'b0, 1'b1, 8'd1,   8'd2,   8'd3,   1'b0},
    '{8'd7,   8'd8,   8'd9,   1'b0, 1'b1, 8'd10,  8'd20,  8'd30,  1'b0},
    '{8'd200, 8'd100, 8'd50,  1'b0, 1'b1, 8'd128, 8'd64,  8'd32,  1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd0,   8'd255, 8'd0,   1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd255, 8'd0,   8'd255, 1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd7,   8'd8,   8'd9,   1'b0},
    '{8'd99,  8'd99,  8'd99,  1'b0, 1'b1, 8'd200, 8'd100, 8'd50,  1'b1}
  };

  // stimulus
  initial begin
    int unsigned w, h, phase;
    int mode, frames;
    filt_pix_t typed_res;
    rst_n = 0;
    in_valid = 0;
    in_pixel_red = 0;
    in_pixel_green = 0;
    in_pixel_blue = 0;
    in_drain = 0;
    cfg_valid = 0;
    cfg_index = REG_WIDTH;
    cfg_data = 0;
    ref_width = RST_WIDTH;
    ref_height = RST_HEIGHT;
    ref_taps03 = RST_TAPS03;
    ref_taps47 = RST_TAPS47;
    ref_tap8 = RST_TAP8;
    foreach (row_upper[i]) begin
      row_upper[i] = '0;
      row_lower[i] = '0;
    end
    restart_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    repeat (4) @(posedge clk);

    // directed frame with width and height below the minimum clamped up
    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd0);
    for (int i = 0; i < 14; i++) begin
      typed_res = {dir_tab[i].exp_red, dir_tab[i].exp_green, dir_tab[i].exp_blue,
                   dir_tab[i].exp_fend};
      send_pix(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, dir_tab[i].drn,
               dir_tab[i].typed, typed_res);
    end
    wait_drained();

    // random frames
    phase = 0;
    while (items_sent < 1650) begin
      w = ($urandom_range(4) != 0) ? $urandom_range(8, 3) : $urandom_range(40, 9);
      h = $urandom_range(6, 3);
      if ($urandom_range(11) == 0) w = $urandom_range(2);
      write_reg(REG_WIDTH, 64'(w));
      write_reg(REG_HEIGHT, 64'(h));
      mode = $urandom_range(2);
      if ($urandom_range(1)) write_reg(REG_TAPS03, {rand_tap(mode), rand_tap(mode),
                                                     rand_tap(mode), rand_tap(mode)});
      if ($urandom_range(1)) write_reg(REG_TAPS47, {rand_tap(mode), rand_tap(mode),
                                                     rand_tap(mode), rand_tap(mode)});
      if ($urandom_range(1)) write_reg(REG_TAP8, {48'($urandom), rand_tap(mode)});
      if ($urandom_range(5) == 0)
        write_reg(3'($urandom_range(REG_UNUSED_TOP, REG_UNUSED)), {$urandom, $urandom});
      w = eff_w();
      h = eff_h();
      calm = ($urandom_range(4) == 0);
      if (phase == 2) begin
        calm = 0;
        long_hold_req = 1;
      end
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        if (f == 1 && $urandom_range(2) == 0) wait_drained();
        run_frame(w, h, f == frames - 1 && $urandom_range(9) == 0);
      end
      wait_drained();
      phase++;
    end

    // extreme taps, geometry writes with the upper data bits set
    calm = 0;
    write_reg(REG_TAPS03, {16'h0200, 16'h0400, 16'h0200, 16'hFC00});
    write_reg(REG_TAPS47, {16'h0200, 16'h0400, 16'hF000, 16'h1800});
    write_reg(REG_TAP8, 64'h0000_0000_0000_0200);
    write_reg(REG_WIDTH, 64'hFFFF_FFFF_FFFF_F005);
    write_reg(REG_HEIGHT, 64'hFFFF_FFFF_FFFF_E003);
    run_frame(eff_w(), eff_h(), 0);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_pix.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
